// ===== rtl/core/slwf_pkg.sv =====
// shared types, codes and the digit address map of the segment lcd write framer
`timescale 1ns / 1ps
`default_nettype none

package slwf_pkg;

    // item kinds carried on the slave-side tuser
    typedef enum logic [1:0] {
        OP_COMMAND = 2'd0,
        OP_DATA    = 2'd1,
        OP_GLYPH   = 2'd2,
        OP_UNUSED  = 2'd3
    } slwf_op_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_SHIFT = 1'b1
    } slwf_state_t;

    localparam logic [2:0] MODE_COMMAND = 3'b100;
    localparam logic [2:0] MODE_DATA    = 3'b101;

    localparam logic [3:0] LEN_COMMAND = 4'd12;
    localparam logic [3:0] LEN_DATA    = 4'd13;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    // display memory address for nibble k of digit d
    function automatic logic [5:0] addr_map(input logic [2:0] digit, input logic [1:0] k);
        logic [5:0] a;
        a = 6'd0;
        case ({digit, k})
            5'b000_00: a = 6'd1;
            5'b000_01: a = 6'd31;
            5'b000_10: a = 6'd30;
            5'b000_11: a = 6'd0;
            5'b001_00: a = 6'd3;
            5'b001_01: a = 6'd29;
            5'b001_10: a = 6'd27;
            5'b001_11: a = 6'd2;
            5'b010_00: a = 6'd5;
            5'b010_01: a = 6'd28;
            5'b010_10: a = 6'd26;
            5'b010_11: a = 6'd4;
            5'b011_00: a = 6'd7;
            5'b011_01: a = 6'd25;
            5'b011_10: a = 6'd24;
            5'b011_11: a = 6'd6;
            5'b100_00: a = 6'd9;
            5'b100_01: a = 6'd23;
            5'b100_10: a = 6'd22;
            5'b100_11: a = 6'd8;
            5'b101_00: a = 6'd11;
            5'b101_01: a = 6'd21;
            5'b101_10: a = 6'd20;
            5'b101_11: a = 6'd10;
            5'b110_00: a = 6'd13;
            5'b110_01: a = 6'd19;
            5'b110_10: a = 6'd18;
            5'b110_11: a = 6'd12;
            5'b111_00: a = 6'd15;
            5'b111_01: a = 6'd17;
            5'b111_10: a = 6'd16;
            5'b111_11: a = 6'd14;
            default:   a = 6'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/segment_lcd_serial_write_framer_unit.sv =====
// top level of the three-wire segment lcd serial write framer
`timescale 1ns / 1ps
`default_nettype none

// Turns write requests for a segment lcd controller into the bit stream of its
// three-wire link, one output beat per write clock pulse, msb first. A command
// (tuser 0) becomes a 12-bit frame: mode 100, eight command bits, a trailing 0.
// A data write (tuser 1) becomes a 13-bit frame: mode 101, six address bits,
// four data bits. A glyph write (tuser 2) splits its 16-bit segment pattern into
// four nibbles, high first, and sends each as a data-write frame to the address
// that a fixed digit-by-nibble map gives, 52 beats in all. Each output beat
// carries the data bit in tdata bit 0, frame end (chip select released after this
// bit) in tuser, and tlast on the final beat caused by the input beat. Kind 3 and
// a glyph whose digit is not below DIGIT_COUNT are taken and dropped with no
// output. The block works on one item at a time: a single down-counter and a
// 13-bit frame register with one bit-select mux deliver one bit per cycle while
// the output side does not stall, and an item holds the input closed until its
// last bit has left the frame register. The output beat sits in its own register,
// so the next input beat can be taken while the last bit still waits downstream.
module segment_lcd_serial_write_framer_unit
    import slwf_pkg::*;
#(
    parameter int DIGIT_COUNT = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // s_tdata from bit 0: command_code[7:0], address[5:0], nibble[3:0],
    // digit_position[2:0], segment_pattern[15:0], zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: opcode[1:0]
    input  wire logic [1:0]             s_tuser,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // m_tdata from bit 0: data_bit, zero fill
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // m_tuser: frame_end
    output logic [0:0]                  m_tuser,
    // run_last
    output logic                        m_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready
);

    localparam logic [3:0] DIGIT_LIMIT = 4'(DIGIT_COUNT);

    // unpacked input fields
    slwf_op_t    in_op;
    logic [7:0]  in_cmd;
    logic [5:0]  in_addr;
    logic [3:0]  in_nib;
    logic [2:0]  in_digit;
    logic [15:0] in_pat;

    assign in_op    = slwf_op_t'(s_tuser);
    assign in_cmd   = s_tdata[7:0];
    assign in_addr  = s_tdata[13:8];
    assign in_nib   = s_tdata[17:14];
    assign in_digit = s_tdata[20:18];
    assign in_pat   = s_tdata[36:21];

    slwf_state_t state_reg, state_next;
    logic [12:0] frame_shift_reg, frame_shift_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [1:0]  nibble_index_reg, nibble_index_next;
    logic [15:0] held_pattern_reg, held_pattern_next;
    logic [2:0]  held_digit_reg, held_digit_next;
    slwf_op_t    held_kind_reg, held_kind_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_bit_reg, out_bit_next;
    logic        out_end_reg, out_end_next;
    logic        out_last_reg, out_last_next;

    logic        in_fire;
    logic        in_start;
    logic        digit_ok;
    logic        emit;
    logic        frame_done;
    logic        more_nibbles;
    logic [1:0]  next_index;
    logic [3:0]  next_part;
    logic [3:0]  bit_sel;

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign digit_ok   = ({1'b0, in_digit} < DIGIT_LIMIT);
    assign in_start   = in_fire && ((in_op == OP_COMMAND) || (in_op == OP_DATA) ||
                                    ((in_op == OP_GLYPH) && digit_ok));

    // one bit leaves whenever the output register is free or being drained
    assign emit         = (state_reg == ST_SHIFT) && (!out_valid_reg || m_tready);
    assign frame_done   = (bit_count_reg == 4'd1);
    assign more_nibbles = (held_kind_reg == OP_GLYPH) && (nibble_index_reg != 2'd3);
    assign next_index   = 2'(nibble_index_reg + 2'd1);
    assign bit_sel      = 4'(bit_count_reg - 4'd1);

    always_comb
    begin
        case (next_index)
            2'd0:    next_part = held_pattern_reg[15:12];
            2'd1:    next_part = held_pattern_reg[11:8];
            2'd2:    next_part = held_pattern_reg[7:4];
            2'd3:    next_part = held_pattern_reg[3:0];
            default: next_part = held_pattern_reg[3:0];
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_start)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (emit && frame_done && !more_nibbles)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // frame loading, shifting and the output register
    always_comb
    begin
        frame_shift_next  = frame_shift_reg;
        bit_count_next    = bit_count_reg;
        nibble_index_next = nibble_index_reg;
        held_pattern_next = held_pattern_reg;
        held_digit_next   = held_digit_reg;
        held_kind_next    = held_kind_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_bit_next      = out_bit_reg;
        out_end_next      = out_end_reg;
        out_last_next     = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_start)
                begin
                    held_kind_next = in_op;
                    case (in_op)
                        OP_COMMAND:
                        begin
                            frame_shift_next = {1'b0, MODE_COMMAND, in_cmd, 1'b0};
                            bit_count_next   = LEN_COMMAND;
                        end
                        OP_DATA:
                        begin
                            frame_shift_next = {MODE_DATA, in_addr, in_nib};
                            bit_count_next   = LEN_DATA;
                        end
                        default:
                        begin
                            held_digit_next   = in_digit;
                            held_pattern_next = in_pat;
                            nibble_index_next = 2'd0;
                            frame_shift_next  = {MODE_DATA, addr_map(in_digit, 2'd0),
                                                 in_pat[15:12]};
                            bit_count_next    = LEN_DATA;
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_bit_next   = frame_shift_reg[bit_sel];
                    out_end_next   = frame_done;
                    out_last_next  = frame_done && !more_nibbles;
                    bit_count_next = 4'(bit_count_reg - 4'd1);
                    // glyph: chain the next nibble's data-write frame
                    if (frame_done && more_nibbles)
                    begin
                        nibble_index_next = next_index;
                        frame_shift_next  = {MODE_DATA,
                                             addr_map(held_digit_reg, next_index),
                                             next_part};
                        bit_count_next    = LEN_DATA;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            bit_count_reg    <= 4'd0;
            nibble_index_reg <= 2'd0;
            held_kind_reg    <= OP_COMMAND;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            bit_count_reg    <= bit_count_next;
            nibble_index_reg <= nibble_index_next;
            held_kind_reg    <= held_kind_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        frame_shift_reg  <= frame_shift_next;
        held_pattern_reg <= held_pattern_next;
        held_digit_reg   <= held_digit_next;
        out_bit_reg      <= out_bit_next;
        out_end_reg      <= out_end_next;
        out_last_reg     <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_bit_reg};
    assign m_tuser  = out_end_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/slwf_checker.sv =====
// port-level checker for the segment lcd write framer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module slwf_checker
    import slwf_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic [1:0]             s_tuser,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic [0:0]             m_tuser,
    input wire logic                   m_tlast,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output beat changed");

    // the last bit of an item always closes a frame
    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("run end without frame end");

    // a command or data write keeps the input closed while it shifts
    a_busy_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready &&
        (s_tuser == OP_COMMAND || s_tuser == OP_DATA) |=> !s_tready)
        else $error("input open right after a frame started");

    // an unused kind is dropped and leaves the input open
    a_unused_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == OP_UNUSED |=> s_tready)
        else $error("unused kind started a frame");

endmodule

bind segment_lcd_serial_write_framer_unit slwf_checker u_slwf_checker (.*);

`default_nettype wire
